// File: src/wllf_pkg.sv
// ----------------------------------------------------------------------------
// wllf_pkg: shared types and constants for the word list line filter
// Byte codes, configuration register indexes, the op queue entry and the
// part-of-speech tag letter table.
// ----------------------------------------------------------------------------
package wllf_pkg;

  localparam int LENGTH_BITS_DEFAULT = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int TAG_N = 15;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_MODE      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_LETTER   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SECOND_ENABLED = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SECOND_LETTER  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_THIRD_ENABLED  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_THIRD_LETTER   = 3'd5;

  // byte codes
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_HYPHEN   = 8'h2D;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_N  = 8'h6E;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_TILDE    = 8'd126;

  // class flag bit positions
  localparam int CF_NONPRINT = 0;
  localparam int CF_SPACE    = 1;
  localparam int CF_HYPHEN   = 2;
  localparam int CF_OTHER    = 3;

  // tag letters N p h V t i A v C P n r D I o, bit i for entry i
  localparam logic [7:0] TAG_LETTERS [TAG_N] = '{
    8'h4E, 8'h70, 8'h68, 8'h56, 8'h74, 8'h69, 8'h41, 8'h76,
    8'h43, 8'h50, 8'h6E, 8'h72, 8'h44, 8'h49, 8'h6F
  };

  typedef logic [7:0] len_out_t;

  typedef struct packed {
    logic       line_mode;
    logic [7:0] first_letter;
    logic       second_enabled;
    logic [7:0] second_letter;
    logic       third_enabled;
    logic [7:0] third_letter;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_WORD,
    OP_TAG,
    OP_CLOSE,
    OP_END
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       chr;
    logic [3:0]       flags;
    logic [TAG_N-1:0] tags;
  } qentry_t;

endpackage

// File: src/wllf_front.sv
// ----------------------------------------------------------------------------
// wllf_front: byte classifier
// Tracks the tag phase, classifies each accepted byte and pushes one op per
// byte that affects the line state.
// ----------------------------------------------------------------------------
module wllf_front (
  input  logic               clk,
  input  logic               rst,
  input  wllf_pkg::cfg_t     cfg,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,  // [7:0] in_byte
  input  logic               s_tuser,  // [0] end_of_input
  input  logic               q_full,
  output logic               push,
  output wllf_pkg::qentry_t  push_entry
);

  logic tag_phase;
  logic tag_phase_next;
  logic accept;
  logic emit;
  logic is_eol;
  logic nonprint;
  logic letter;
  logic [7:0] tag_chr;
  logic [3:0] word_flags;
  logic [wllf_pkg::TAG_N-1:0] tag_hits;

  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;
  assign push = accept && emit;

  assign is_eol = (s_tdata == wllf_pkg::CH_LF) || (s_tdata == wllf_pkg::CH_CR);
  assign nonprint = (s_tdata < wllf_pkg::CH_SPACE) || (s_tdata > wllf_pkg::CH_TILDE);
  assign letter = ((s_tdata >= wllf_pkg::CH_UPPER_A) && (s_tdata <= wllf_pkg::CH_UPPER_Z)) ||
                  ((s_tdata >= wllf_pkg::CH_LOWER_A) && (s_tdata <= wllf_pkg::CH_LOWER_Z));
  assign tag_chr = (s_tdata == wllf_pkg::CH_BANG) ? wllf_pkg::CH_LOWER_N : s_tdata;

  always_comb begin
    word_flags = '0;
    if (nonprint) begin
      word_flags[wllf_pkg::CF_NONPRINT] = 1'b1;
    end else if (!letter) begin
      if (s_tdata == wllf_pkg::CH_SPACE) begin
        word_flags[wllf_pkg::CF_SPACE] = 1'b1;
      end else if (s_tdata == wllf_pkg::CH_HYPHEN) begin
        word_flags[wllf_pkg::CF_HYPHEN] = 1'b1;
      end else begin
        word_flags[wllf_pkg::CF_OTHER] = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < wllf_pkg::TAG_N; i++) begin
      tag_hits[i] = (tag_chr == wllf_pkg::TAG_LETTERS[i]);
    end
  end

  // op decode; CR/LF in the word part of a tagged line is dropped
  always_comb begin
    emit = 1'b1;
    tag_phase_next = tag_phase;
    push_entry.op = wllf_pkg::OP_WORD;
    push_entry.chr = nonprint ? wllf_pkg::CH_QUESTION : s_tdata;
    push_entry.flags = word_flags;
    push_entry.tags = '0;
    if (s_tuser) begin
      push_entry.op = wllf_pkg::OP_END;
      tag_phase_next = 1'b0;
    end else if (!cfg.line_mode) begin
      if (is_eol) begin
        push_entry.op = wllf_pkg::OP_CLOSE;
        tag_phase_next = 1'b0;
      end
    end else if (!tag_phase) begin
      if (is_eol) begin
        emit = 1'b0;
      end else if (s_tdata == wllf_pkg::CH_BSLASH) begin
        emit = 1'b0;
        tag_phase_next = 1'b1;
      end
    end else if (is_eol) begin
      push_entry.op = wllf_pkg::OP_CLOSE;
      tag_phase_next = 1'b0;
    end else begin
      push_entry.op = wllf_pkg::OP_TAG;
      push_entry.flags = {3'b000, nonprint};
      push_entry.tags = tag_hits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_phase <= 1'b0;
    end else if (accept) begin
      tag_phase <= tag_phase_next;
    end
  end

endmodule

// File: src/wllf_queue.sv
// ----------------------------------------------------------------------------
// wllf_queue: op queue
// Two-entry register FIFO between the classifier and the line builder.
// ----------------------------------------------------------------------------
module wllf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wllf_pkg::qentry_t  push_entry,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output wllf_pkg::qentry_t  head
);

  wllf_pkg::qentry_t entries [wllf_pkg::QDEPTH];
  logic [wllf_pkg::QPTR_W-1:0] wr_ptr;
  logic [wllf_pkg::QPTR_W-1:0] rd_ptr;
  logic [wllf_pkg::QCNT_W-1:0] count;

  assign full = (count == wllf_pkg::QCNT_W'(wllf_pkg::QDEPTH));
  assign valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop)) else $error("op queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !valid)) else $error("op queue underflow");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push && !pop && !valid |=> valid && (head == $past(push_entry)))
    else $error("pushed transaction not at head");

endmodule

// File: src/wllf_back.sv
// ----------------------------------------------------------------------------
// wllf_back: line builder
// Applies queued ops to the line state, checks the prefix filter at line end
// and holds the record in the output register.
// ----------------------------------------------------------------------------
module wllf_back #(
  parameter int LENGTH_BITS = wllf_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  wllf_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  wllf_pkg::qentry_t  q_head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,
  output logic               m_tuser
);

  localparam int LW = LENGTH_BITS;
  localparam logic [LW-1:0] LEN_MAX = '1;

  logic [7:0] chars [3];
  logic [LW-1:0] len;
  logic [3:0] flags;
  logic [wllf_pkg::TAG_N-1:0] tags;
  logic prefix_ok;
  logic emit_rec;
  logic [31:0] rec_data;

  assign pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    prefix_ok = (len != '0) && (chars[0] == cfg.first_letter);
    if (cfg.second_enabled) begin
      if (len > LW'(1)) begin
        if (chars[1] != cfg.second_letter) begin
          prefix_ok = 1'b0;
        end
        if (cfg.third_enabled) begin
          if (len > LW'(2)) begin
            if (chars[2] != cfg.third_letter) begin
              prefix_ok = 1'b0;
            end
          end else if (cfg.third_letter != wllf_pkg::CH_LOWER_A) begin
            prefix_ok = 1'b0;
          end
        end
      end else if (cfg.second_letter != wllf_pkg::CH_LOWER_A) begin
        prefix_ok = 1'b0;
      end
    end
  end

  // tdata: len, flags, tags, pass, keep, pad
  assign rec_data = {3'b000, prefix_ok && (flags == '0), prefix_ok, tags, flags,
                     wllf_pkg::len_out_t'(len)};

  always_comb begin
    unique case (q_head.op)
      wllf_pkg::OP_CLOSE: emit_rec = (len != '0);
      wllf_pkg::OP_END:   emit_rec = 1'b1;
      default:            emit_rec = 1'b0;
    endcase
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      flags <= '0;
      tags <= '0;
      chars[0] <= '0;
      chars[1] <= '0;
      chars[2] <= '0;
    end else if (pop) begin
      unique case (q_head.op)
        wllf_pkg::OP_WORD: begin
          flags <= flags | q_head.flags;
          for (int i = 0; i < 3; i++) begin
            if (len == LW'(i)) begin
              chars[i] <= q_head.chr;
            end
          end
          if (len != LEN_MAX) begin
            len <= len + 1'b1;
          end
        end
        wllf_pkg::OP_TAG: begin
          flags <= flags | q_head.flags;
          tags <= tags | q_head.tags;
        end
        default: begin
          len <= '0;
          flags <= '0;
          tags <= '0;
          chars[0] <= '0;
          chars[1] <= '0;
          chars[2] <= '0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && emit_rec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit_rec) begin
      m_tuser <= (q_head.op == wllf_pkg::OP_END);
      m_tdata <= (q_head.op == wllf_pkg::OP_END) ? '0 : rec_data;
    end
  end

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == '0)) else $error("end record not clear");

  a_rec_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[7:0] != '0) || (LW > 8))
    else $error("record with empty word");

  a_keep_pass: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |-> m_tdata[27]) else $error("keep without prefix pass");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    pop && (q_head.op == wllf_pkg::OP_CLOSE || q_head.op == wllf_pkg::OP_END)
    |=> (len == '0) && (flags == '0) && (tags == '0)) else $error("line not cleared");

endmodule

// File: src/word_list_line_filter.sv
// ----------------------------------------------------------------------------
// word_list_line_filter: word list line filter top level
// Byte stream in, one record per non-empty line and an end record out, with prefix filter.
// ----------------------------------------------------------------------------
// channel   dir   handshake            payload
// s_        in    s_tvalid/s_tready    tdata in_byte, tuser end_of_input
// m_        out   m_tvalid/m_tready    tdata record fields, tuser at_end
// cfg_      in    cfg_we               cfg_addr register index, cfg_data value
//
// One byte per cycle sustained while the output is not stalled; a record reaches
// the output register once the closing byte is accepted, through the op queue
// write and then the line builder. Rate is set by the line builder update.
// Synchronous reset clears the line state, the queue and loads register defaults.
// A stalled output holds the record; the two-entry op queue keeps the input open
// until it fills.
// ----------------------------------------------------------------------------
module word_list_line_filter #(
  parameter int LENGTH_BITS = wllf_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] in_byte
  input  logic                            s_tuser,   // [0] end_of_input
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] word_length, [8] not_printable, [9] space flag, [10] hyphen flag,
  // [11] other symbol flag, [26:12] pos_mask, [27] passes_prefix, [28] keep
  output logic [31:0]                     m_tdata,
  output logic                            m_tuser,   // [0] at_end
  input  logic                            cfg_we,
  input  logic [wllf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wllf_pkg::CFG_DATA_W-1:0] cfg_data
);

  wllf_pkg::cfg_t cfg;
  wllf_pkg::qentry_t push_entry;
  wllf_pkg::qentry_t q_head;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_mode <= 1'b0;
      cfg.first_letter <= wllf_pkg::CH_LOWER_A;
      cfg.second_enabled <= 1'b0;
      cfg.second_letter <= wllf_pkg::CH_LOWER_A;
      cfg.third_enabled <= 1'b0;
      cfg.third_letter <= wllf_pkg::CH_LOWER_A;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        wllf_pkg::REG_LINE_MODE:      cfg.line_mode <= cfg_data[0];
        wllf_pkg::REG_FIRST_LETTER:   cfg.first_letter <= cfg_data;
        wllf_pkg::REG_SECOND_ENABLED: cfg.second_enabled <= cfg_data[0];
        wllf_pkg::REG_SECOND_LETTER:  cfg.second_letter <= cfg_data;
        wllf_pkg::REG_THIRD_ENABLED:  cfg.third_enabled <= cfg_data[0];
        wllf_pkg::REG_THIRD_LETTER:   cfg.third_letter <= cfg_data;
        default: ;
      endcase
    end
  end

  wllf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  wllf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  wllf_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
